// ----- src/i2cmts_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Types, codes and microcode store of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 16;
  localparam int unsigned BATCH_MAX      = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned WORD_W  = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned THR_W   = 4;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PC_W    = 5;

  // command word flag bits
  localparam logic [WORD_W-1:0] CMDW_READ    = 11'h100;
  localparam logic [WORD_W-1:0] CMDW_STOP    = 11'h200;
  localparam logic [WORD_W-1:0] CMDW_RESTART = 11'h400;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_START    = 3'd0,
    CMD_TX_SPACE = 3'd1,
    CMD_TX_EMPTY = 3'd2,
    CMD_RX_BYTE  = 3'd3,
    CMD_STOP     = 3'd4,
    CMD_ERROR    = 3'd5
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_MASK = 3'd0,
    KIND_CMD  = 3'd1,
    KIND_RXB  = 3'd2,
    KIND_DONE = 3'd3,
    KIND_FAIL = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ADDR = 2'd0,
    REG_WRITE_COUNT = 2'd1,
    REG_READ_COUNT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  // condition tested by a microcode step
  typedef enum logic [2:0] {
    T_NONE,
    T_TX_OK,
    T_TXE_OK,
    T_RX_OK,
    T_IDLE,
    T_STOP_RD,
    T_BATCH_ZERO,
    T_MORE
  } test_e;

  // datapath action of a microcode step
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_WRITE,
    ACT_BATCH,
    ACT_READ,
    ACT_RX,
    ACT_TO_READ,
    ACT_IDLE
  } act_e;

  typedef struct packed {
    logic  dispatch;
    test_e test;
    logic  jump_on;
    pc_t   target;
    logic  halt;
    act_e  act;
    logic  emit;
    kind_e kind;
    logic  use_thr;
    logic  last;
  } ucode_t;

  // program addresses
  localparam pc_t PC_DISP  = 5'd0;
  localparam pc_t PC_START = 5'd1;
  localparam pc_t PC_TX    = 5'd2;
  localparam pc_t PC_TX_WR = 5'd3;
  localparam pc_t PC_TXE   = 5'd4;
  localparam pc_t PC_BATCH = 5'd5;
  localparam pc_t PC_BZERO = 5'd6;
  localparam pc_t PC_RDLP  = 5'd7;
  localparam pc_t PC_EMPTY = 5'd8;
  localparam pc_t PC_RX    = 5'd9;
  localparam pc_t PC_RX_PS = 5'd10;
  localparam pc_t PC_STOP  = 5'd11;
  localparam pc_t PC_STRD  = 5'd12;
  localparam pc_t PC_TORD  = 5'd13;
  localparam pc_t PC_DONE  = 5'd14;
  localparam pc_t PC_ERR   = 5'd15;
  localparam pc_t PC_FAIL  = 5'd16;
  localparam pc_t PC_END   = 5'd17;

  function automatic ucode_t uw(logic disp, test_e t, logic jon, pc_t tgt, logic halt,
                                act_e a, logic emit, kind_e k, logic thr, logic last);
    ucode_t w;
    w.dispatch = disp;
    w.test     = t;
    w.jump_on  = jon;
    w.target   = tgt;
    w.halt     = halt;
    w.act      = a;
    w.emit     = emit;
    w.kind     = k;
    w.use_thr  = thr;
    w.last     = last;
    return w;
  endfunction

  // microcode store
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_DISP:  w = uw(1'b1, T_NONE, 1'b0, PC_END, 1'b0, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_START: w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_START, 1'b1, KIND_MASK, 1'b0, 1'b1);
      PC_TX:    w = uw(1'b0, T_TX_OK, 1'b0, PC_END, 1'b0, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_TX_WR: w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_WRITE, 1'b1, KIND_CMD, 1'b0, 1'b1);
      PC_TXE:   w = uw(1'b0, T_TXE_OK, 1'b0, PC_END, 1'b0, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_BATCH: w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b0, ACT_BATCH, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_BZERO: w = uw(1'b0, T_BATCH_ZERO, 1'b1, PC_EMPTY, 1'b0, ACT_NONE, 1'b0, KIND_MASK,
                       1'b0, 1'b0);
      PC_RDLP:  w = uw(1'b0, T_MORE, 1'b1, PC_RDLP, 1'b1, ACT_READ, 1'b1, KIND_CMD, 1'b1, 1'b0);
      PC_EMPTY: w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_NONE, 1'b1, KIND_MASK, 1'b1, 1'b1);
      PC_RX:    w = uw(1'b0, T_RX_OK, 1'b0, PC_END, 1'b0, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_RX_PS: w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_RX, 1'b1, KIND_RXB, 1'b0, 1'b1);
      PC_STOP:  w = uw(1'b0, T_IDLE, 1'b1, PC_END, 1'b0, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_STRD:  w = uw(1'b0, T_STOP_RD, 1'b0, PC_DONE, 1'b0, ACT_NONE, 1'b0, KIND_MASK,
                       1'b0, 1'b0);
      PC_TORD:  w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_TO_READ, 1'b1, KIND_MASK,
                       1'b0, 1'b1);
      PC_DONE:  w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_IDLE, 1'b1, KIND_DONE, 1'b0, 1'b1);
      PC_ERR:   w = uw(1'b0, T_IDLE, 1'b1, PC_END, 1'b0, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
      PC_FAIL:  w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_IDLE, 1'b1, KIND_FAIL, 1'b0, 1'b1);
      default:  w = uw(1'b0, T_NONE, 1'b0, PC_END, 1'b1, ACT_NONE, 1'b0, KIND_MASK, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

  // entry point of each command's routine
  function automatic pc_t cmd_entry(logic [CMD_W-1:0] c);
    pc_t p;
    unique case (c)
      CMD_START:    p = PC_START;
      CMD_TX_SPACE: p = PC_TX;
      CMD_TX_EMPTY: p = PC_TXE;
      CMD_RX_BYTE:  p = PC_RX;
      CMD_STOP:     p = PC_STOP;
      CMD_ERROR:    p = PC_ERR;
      default:      p = PC_END;
    endcase
    return p;
  endfunction

endpackage

// ----- src/i2cmts_in_if.sv -----
// ----------------------------------------------------------------------------
// i2cmts_in_if
// Event channel into the sequencer: valid/ready with one event per beat.
// ----------------------------------------------------------------------------
interface i2cmts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic [7:0] rx_data;
  logic       rx_fifo_drained;
  logic       arb_lost_flag;
  logic       overrun_flag;

  modport source (
    output valid, command, tx_byte, rx_data, rx_fifo_drained, arb_lost_flag, overrun_flag,
    input  ready
  );
  modport sink (
    input  valid, command, tx_byte, rx_data, rx_fifo_drained, arb_lost_flag, overrun_flag,
    output ready
  );
endinterface

// ----- src/i2cmts_out_if.sv -----
// ----------------------------------------------------------------------------
// i2cmts_out_if
// Result channel out of the sequencer: valid/ready with one result per beat.
// ----------------------------------------------------------------------------
interface i2cmts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [10:0] cmd_word;
  logic [7:0]  rx_byte;
  logic [3:0]  rx_threshold;
  logic        tx_empty_irq_on;
  logic        rx_full_irq_on;
  logic        arb_lost;
  logic        overrun;
  logic [9:0]  address_out;
  logic        last;

  modport source (
    output valid, kind, cmd_word, rx_byte, rx_threshold, tx_empty_irq_on, rx_full_irq_on,
           arb_lost, overrun, address_out, last,
    input  ready
  );
  modport sink (
    input  valid, kind, cmd_word, rx_byte, rx_threshold, tx_empty_irq_on, rx_full_irq_on,
           arb_lost, overrun, address_out, last,
    output ready
  );
endinterface

// ----- src/i2c_master_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Microcoded sequencer for one I2C master write-then-read transfer.
// ----------------------------------------------------------------------------
// Takes one controller event per beat on item_i and answers with zero or more
// result beats on result_o, the final one of each event flagged by last. An
// event is taken only while the sequencer is free; the microcode then runs
// one step per cycle: a dispatch step, then the routine of the command.
// A tx empty event is ignored, answered with a bare mask update when the read
// request is empty, or answered with one read command per read left, up to
// min(FIFO_DEPTH,16) per batch. The input reopens in the cycle after the last
// step. A step that emits a result waits while the output register is still
// full and not taken; the next event is accepted as soon as the last step of
// the previous one has run, even if its result still waits. Configuration
// (target address, write and read counts) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while no event
// is in progress, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  i2cmts_in_if.sink             item_i,
  i2cmts_out_if.source          result_o
);

  // read batch size cap and the width of the batch counter
  localparam int unsigned Cap  = (FIFO_DEPTH < BATCH_MAX) ? FIFO_DEPTH : BATCH_MAX;
  localparam int unsigned CntW = $clog2(Cap + 1);

  // configuration registers
  logic [ADDR_W-1:0]  tgt_addr_q;
  logic [COUNT_W-1:0] wr_cnt_q, rd_cnt_q;

  // transfer state
  phase_e             phase_q, phase_d;
  logic [COUNT_W-1:0] writes_left_q, writes_left_d;
  logic [COUNT_W-1:0] reads_left_q, reads_left_d;
  logic               restart_q, restart_d;
  logic               tx_en_q, tx_en_d;
  logic               rx_en_q, rx_en_d;

  // sequencer
  logic               busy_q, busy_d;
  pc_t                pc_q, pc_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [THR_W-1:0]   thr_q, thr_d;
  ucode_t             cw;
  logic               tres, jump, fire, accept;

  // latched event
  logic [CMD_W-1:0]   cmd_q;
  logic [BYTE_W-1:0]  tx_byte_q, rx_data_q;
  logic               drained_q, arb_q, ovr_q;

  // output register
  logic               out_valid_q;
  logic [KIND_W-1:0]  kind_q;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [BYTE_W-1:0]  rxb_q;
  logic [THR_W-1:0]   othr_q;
  logic               otx_q, orx_q, oarb_q, oovr_q, olast_q;
  logic [ADDR_W-1:0]  oaddr_q;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_addr_q <= '0;
      wr_cnt_q   <= '0;
      rd_cnt_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_ADDR: tgt_addr_q <= cfg_data_i[ADDR_W-1:0];
        REG_WRITE_COUNT: wr_cnt_q   <= cfg_data_i[COUNT_W-1:0];
        REG_READ_COUNT:  rd_cnt_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes: take an event only while no routine runs; a step that emits
  // runs only when the output register is free or being emptied.
  // ---------------------------------------------------------------------------
  assign item_i.ready = !busy_q;
  assign accept       = item_i.valid && !busy_q;
  assign cw           = ucode_rom(pc_q);
  assign fire         = busy_q && (!cw.emit || !out_valid_q || result_o.ready);

  // ---------------------------------------------------------------------------
  // Condition under test of the current step
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (cw.test)
      T_TX_OK:      tres = (phase_q == PH_WRITE) && (writes_left_q != '0);
      T_TXE_OK:     tres = (phase_q == PH_READ) && tx_en_q;
      T_RX_OK:      tres = (phase_q == PH_READ) && rx_en_q;
      T_IDLE:       tres = (phase_q == PH_IDLE);
      T_STOP_RD:    tres = (phase_q == PH_WRITE) && (reads_left_q != '0);
      T_BATCH_ZERO: tres = (cnt_q == '0);
      T_MORE:       tres = (cnt_q > CntW'(1));
      default:      tres = 1'b0;
    endcase
  end

  assign jump = (cw.test != T_NONE) && (tres == cw.jump_on);

  // ---------------------------------------------------------------------------
  // Step counter: dispatch, jump, advance or halt
  // ---------------------------------------------------------------------------
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = PC_DISP;
    end else if (fire) begin
      priority if (cw.dispatch) begin
        pc_d = cmd_entry(cmd_q);
      end else if (jump) begin
        pc_d = cw.target;
      end else if (cw.halt) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + pc_t'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: the action of the current step
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d       = phase_q;
    writes_left_d = writes_left_q;
    reads_left_d  = reads_left_q;
    restart_d     = restart_q;
    tx_en_d       = tx_en_q;
    rx_en_d       = rx_en_q;
    cnt_d         = cnt_q;
    thr_d         = thr_q;
    word_d        = '0;
    if (fire) begin
      unique case (cw.act)
        ACT_START: begin
          writes_left_d = wr_cnt_q;
          reads_left_d  = rd_cnt_q;
          restart_d     = 1'b0;
          phase_d       = (wr_cnt_q != '0) ? PH_WRITE : PH_READ;
          tx_en_d       = 1'b1;
          rx_en_d       = 1'b0;
        end
        ACT_WRITE: begin
          // stop goes with the final byte of the write phase
          word_d        = {{(WORD_W-BYTE_W){1'b0}}, tx_byte_q}
                          | ((writes_left_q == COUNT_W'(1)) ? CMDW_STOP : '0);
          writes_left_d = writes_left_q - COUNT_W'(1);
          if (writes_left_q == COUNT_W'(1)) begin
            tx_en_d = 1'b0;
          end
        end
        ACT_BATCH: begin
          cnt_d   = (reads_left_q < COUNT_W'(Cap)) ? reads_left_q[CntW-1:0] : CntW'(Cap);
          thr_d   = (cnt_d > CntW'(1)) ? THR_W'(cnt_d - CntW'(1)) : '0;
          tx_en_d = 1'b0;
          rx_en_d = 1'b1;
        end
        ACT_READ: begin
          // restart rides on the first read after the write phase
          word_d       = CMDW_READ
                         | (restart_q ? CMDW_RESTART : '0)
                         | ((reads_left_q == COUNT_W'(1)) ? CMDW_STOP : '0);
          restart_d    = 1'b0;
          reads_left_d = reads_left_q - COUNT_W'(1);
          cnt_d        = cnt_q - CntW'(1);
        end
        ACT_RX: begin
          if (drained_q) begin
            if (reads_left_q == '0) begin
              rx_en_d = 1'b0;
              tx_en_d = 1'b0;
            end else begin
              tx_en_d = 1'b1;
            end
          end
        end
        ACT_TO_READ: begin
          phase_d   = PH_READ;
          restart_d = 1'b1;
          tx_en_d   = 1'b1;
        end
        ACT_IDLE: begin
          phase_d = PH_IDLE;
          tx_en_d = 1'b0;
          rx_en_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      writes_left_q <= '0;
      reads_left_q  <= '0;
      restart_q     <= 1'b0;
      tx_en_q       <= 1'b0;
      rx_en_q       <= 1'b0;
      busy_q        <= 1'b0;
      pc_q          <= PC_DISP;
      cnt_q         <= '0;
      thr_q         <= '0;
    end else begin
      phase_q       <= phase_d;
      writes_left_q <= writes_left_d;
      reads_left_q  <= reads_left_d;
      restart_q     <= restart_d;
      tx_en_q       <= tx_en_d;
      rx_en_q       <= rx_en_d;
      busy_q        <= busy_d;
      pc_q          <= pc_d;
      cnt_q         <= cnt_d;
      thr_q         <= thr_d;
    end
  end

  // hold the accepted event for the routine
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= item_i.command;
      tx_byte_q <= item_i.tx_byte;
      rx_data_q <= item_i.rx_data;
      drained_q <= item_i.rx_fifo_drained;
      arb_q     <= item_i.arb_lost_flag;
      ovr_q     <= item_i.overrun_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on an emitting step, drop once taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && cw.emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && cw.emit) begin
      kind_q  <= cw.kind;
      word_q  <= word_d;
      rxb_q   <= (cw.act == ACT_RX) ? rx_data_q : '0;
      othr_q  <= cw.use_thr ? thr_q : '0;
      otx_q   <= tx_en_d;
      orx_q   <= rx_en_d;
      oarb_q  <= (cw.kind == KIND_FAIL) ? arb_q : 1'b0;
      oovr_q  <= (cw.kind == KIND_FAIL) ? ovr_q : 1'b0;
      oaddr_q <= (cw.act == ACT_START) ? tgt_addr_q : '0;
      olast_q <= cw.last || ((cw.act == ACT_READ) && (cnt_q == CntW'(1)));
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.kind            = kind_q;
  assign result_o.cmd_word        = word_q;
  assign result_o.rx_byte         = rxb_q;
  assign result_o.rx_threshold    = othr_q;
  assign result_o.tx_empty_irq_on = otx_q;
  assign result_o.rx_full_irq_on  = orx_q;
  assign result_o.arb_lost        = oarb_q;
  assign result_o.overrun         = oovr_q;
  assign result_o.address_out     = oaddr_q;
  assign result_o.last            = olast_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // batch counter never exceeds the cap
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Cap))
    else $error("read batch counter above cap");

  // reads are only outstanding in a batch while in the read phase
  a_batch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (phase_q == PH_READ))
    else $error("read batch pending outside read phase");

  // each read command takes exactly one off the reads left
  a_read_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cw.act == ACT_READ)) |=> (reads_left_q == $past(reads_left_q) - COUNT_W'(1)))
    else $error("reads left not decremented by a read command");

  // the final emitting step of a routine flags its result as last
  a_halt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cw.emit && cw.halt && !jump) |=> (result_o.valid && result_o.last))
    else $error("final result of an event not marked last");

endmodule
